FILE: rtl/core/e2q_pkg.sv
// shared types, constants and the cordic angle table for the euler to quaternion block
`timescale 1ns / 1ps

package e2q_pkg;

    localparam int ANGLE_WIDTH_DEF       = 16;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int TABLE_LEN             = 24;

    localparam int ROT_W   = 34;
    localparam int TRIG_W  = 18;
    localparam int PAIR_W  = 2 * TRIG_W;
    localparam int TRIP_W  = 3 * TRIG_W;
    localparam int QUAT_W  = 16;

    localparam logic [47:0] K_RADIANS = 48'd5468522205;
    localparam logic [47:0] K_DEGREES = 48'd6108397932;
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = ROT_W'(652032874);

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic [1:0]              q;
    } e2q_rot_t;

    typedef e2q_rot_t [2:0] e2q_lanes_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] x;
    } e2q_quat_t;

    // rotation angle of each step in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input int idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd536870912;
            1:       v = 30'd316933406;
            2:       v = 30'd167458907;
            3:       v = 30'd85004756;
            4:       v = 30'd42667331;
            5:       v = 30'd21354465;
            6:       v = 30'd10679838;
            7:       v = 30'd5340245;
            8:       v = 30'd2670163;
            9:       v = 30'd1335087;
            10:      v = 30'd667544;
            11:      v = 30'd333772;
            12:      v = 30'd166886;
            13:      v = 30'd83443;
            14:      v = 30'd41722;
            15:      v = 30'd20861;
            16:      v = 30'd10430;
            17:      v = 30'd5215;
            18:      v = 30'd2608;
            19:      v = 30'd1304;
            20:      v = 30'd652;
            21:      v = 30'd326;
            22:      v = 30'd163;
            23:      v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/e2q_front.sv
// half-angle phase multiply and quadrant reduction, two registered stages
`timescale 1ns / 1ps

module e2q_front #(
    parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              degrees,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0][ANGLE_WIDTH-1:0]       angles,
    output logic                              out_valid,
    input  logic                              out_ready,
    output e2q_pkg::e2q_lanes_t               out_lanes
);

    logic        ph_valid_reg;
    logic [31:0] ph_reg [3];
    logic        rd_valid_reg;
    e2q_pkg::e2q_lanes_t rd_reg;
    logic        ph_ready;
    logic        rd_ready;

    assign rd_ready = !rd_valid_reg || out_ready;
    assign ph_ready = !ph_valid_reg || rd_ready;
    assign in_ready = ph_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ph_ready)
                ph_valid_reg <= in_valid;
            if (rd_ready)
                rd_valid_reg <= ph_valid_reg;
        end
    end

    logic [47:0] k_sel;
    assign k_sel = degrees ? e2q_pkg::K_DEGREES : e2q_pkg::K_RADIANS;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic [47:0] ext;
        logic [47:0] prod;
        logic [31:0] qsum;
        logic [1:0]  quad;
        logic [31:0] resid;

        assign ext   = {{(48-ANGLE_WIDTH){angles[a][ANGLE_WIDTH-1]}}, angles[a]};
        // only the low 48 bits of the product reach the phase
        assign prod  = ext * k_sel + 48'h8000;
        assign qsum  = ph_reg[a] + 32'h2000_0000;
        assign quad  = qsum[31:30];
        assign resid = ph_reg[a] - {quad, 30'd0};

        always_ff @(posedge clk)
        begin
            if (ph_ready && in_valid)
                ph_reg[a] <= prod[47:16];
            if (rd_ready && ph_valid_reg)
            begin
                rd_reg[a].x <= e2q_pkg::CORDIC_GAIN;
                rd_reg[a].y <= '0;
                rd_reg[a].z <= {{(e2q_pkg::ROT_W-32){resid[31]}}, resid};
                rd_reg[a].q <= quad;
            end
        end
    end

    assign out_valid = rd_valid_reg;
    assign out_lanes = rd_reg;

endmodule

FILE: rtl/core/e2q_cordic_cell.sv
// one registered cordic rotation step for all three axes
`timescale 1ns / 1ps

module e2q_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  e2q_pkg::e2q_lanes_t in_lanes,
    output logic                out_valid,
    input  logic                out_ready,
    output e2q_pkg::e2q_lanes_t out_lanes
);

    localparam logic signed [e2q_pkg::ROT_W-1:0] ATAN =
        {{(e2q_pkg::ROT_W-30){1'b0}}, e2q_pkg::atan_turn(SHIFT)};

    logic                valid_reg;
    e2q_pkg::e2q_lanes_t lanes_reg;
    e2q_pkg::e2q_lanes_t lanes_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            lanes_next[a].q = in_lanes[a].q;
            if (!in_lanes[a].z[e2q_pkg::ROT_W-1])
            begin
                lanes_next[a].x = in_lanes[a].x - (in_lanes[a].y >>> SHIFT);
                lanes_next[a].y = in_lanes[a].y + (in_lanes[a].x >>> SHIFT);
                lanes_next[a].z = in_lanes[a].z - ATAN;
            end
            else
            begin
                lanes_next[a].x = in_lanes[a].x + (in_lanes[a].y >>> SHIFT);
                lanes_next[a].y = in_lanes[a].y - (in_lanes[a].x >>> SHIFT);
                lanes_next[a].z = in_lanes[a].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            lanes_reg <= lanes_next;
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

FILE: rtl/core/e2q_back.sv
// sine and cosine rounding, triple products and q1.14 output register
`timescale 1ns / 1ps

module e2q_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  e2q_pkg::e2q_lanes_t in_lanes,
    output logic                out_valid,
    input  logic                out_ready,
    output e2q_pkg::e2q_quat_t  out_quat
);

    localparam int TW = e2q_pkg::TRIG_W;
    localparam int PW = e2q_pkg::PAIR_W;
    localparam int RW = e2q_pkg::TRIP_W;
    localparam int SW = RW + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    assign r4 = !v4_reg || out_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: round to q1.16 and unfold the quadrant
    logic signed [TW-1:0] s_reg [3];
    logic signed [TW-1:0] c_reg [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_trig
        logic signed [e2q_pkg::ROT_W-1:0] xr, yr;
        logic signed [TW-1:0] cs, sn;
        logic signed [TW-1:0] s_next, c_next;

        assign xr = (in_lanes[a].x + e2q_pkg::ROT_W'(8192)) >>> 14;
        assign yr = (in_lanes[a].y + e2q_pkg::ROT_W'(8192)) >>> 14;
        assign cs = xr[TW-1:0];
        assign sn = yr[TW-1:0];

        always_comb
        begin
            case (in_lanes[a].q)
                2'd0:
                begin
                    c_next = cs;
                    s_next = sn;
                end
                2'd1:
                begin
                    c_next = -sn;
                    s_next = cs;
                end
                2'd2:
                begin
                    c_next = -cs;
                    s_next = -sn;
                end
                default:
                begin
                    c_next = sn;
                    s_next = -cs;
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (r1 && in_valid)
            begin
                s_reg[a] <= s_next;
                c_reg[a] <= c_next;
            end
        end
    end

    // stage 2: y and z pair products
    logic signed [PW-1:0] cycz_reg, sysz_reg, sycz_reg, cysz_reg;
    logic signed [TW-1:0] sx_reg, cx_reg;

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            cycz_reg <= c_reg[1] * c_reg[2];
            sysz_reg <= s_reg[1] * s_reg[2];
            sycz_reg <= s_reg[1] * c_reg[2];
            cysz_reg <= c_reg[1] * s_reg[2];
            sx_reg   <= s_reg[0];
            cx_reg   <= c_reg[0];
        end
    end

    // stage 3: the eight triple products
    logic signed [RW-1:0] p_reg [8];

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
        begin
            p_reg[0] <= sx_reg * cycz_reg;
            p_reg[1] <= cx_reg * sysz_reg;
            p_reg[2] <= cx_reg * sycz_reg;
            p_reg[3] <= sx_reg * cysz_reg;
            p_reg[4] <= sx_reg * sycz_reg;
            p_reg[5] <= cx_reg * cysz_reg;
            p_reg[6] <= cx_reg * cycz_reg;
            p_reg[7] <= sx_reg * sysz_reg;
        end
    end

    function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_q14(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + (SW'(1) <<< 33)) >>> 34;
        if (r > SW'(16384))
            r = SW'(16384);
        else if (r < -SW'(16384))
            r = -SW'(16384);
        return r[e2q_pkg::QUAT_W-1:0];
    endfunction

    // stage 4: sums, rounding and saturation
    e2q_pkg::e2q_quat_t quat_reg;

    always_ff @(posedge clk)
    begin
        if (r4 && v3_reg)
        begin
            quat_reg.x <= to_q14(SW'(p_reg[0]) + SW'(p_reg[1]));
            quat_reg.y <= to_q14(SW'(p_reg[2]) - SW'(p_reg[3]));
            quat_reg.z <= to_q14(SW'(p_reg[4]) + SW'(p_reg[5]));
            quat_reg.w <= to_q14(SW'(p_reg[6]) - SW'(p_reg[7]));
        end
    end

    assign out_valid = v4_reg;
    assign out_quat  = quat_reg;

endmodule

FILE: rtl/core/euler_to_quaternion.sv
// top level: euler angles (x, y, z order) to unit quaternion, fully pipelined
//
// channel   direction  payload
// s_axis    in         angle_about_x, angle_about_y, angle_about_z
// m_axis    out        quat_x, quat_y, quat_z, quat_w (q1.14)
// cfg       in         angles_in_degrees
//
// one item per cycle while the output is not stalled; the row of cordic cells (CORDIC_ITERATIONS,
// capped at 24) sits between the phase multiply and reduction stages and the product stages
// each stage has its own valid bit, so bubbles close up while the output stalls
// reset clears all valid bits and the unit register to radians

`timescale 1ns / 1ps

module euler_to_quaternion #(
    parameter int ANGLE_WIDTH       = e2q_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = e2q_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // angle_about_x, angle_about_y, angle_about_z, zero fill
    input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [63:0]                m_axis_tdata,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata
);

    localparam int STEPS = (CORDIC_ITERATIONS < e2q_pkg::TABLE_LEN) ?
                           CORDIC_ITERATIONS : e2q_pkg::TABLE_LEN;

    logic degrees_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            degrees_reg <= 1'b0;
        else if (cfg_we)
            degrees_reg <= cfg_wdata;
    end

    logic [2:0][ANGLE_WIDTH-1:0] angles;
    assign angles = s_axis_tdata[3*ANGLE_WIDTH-1:0];

    logic                valid_chain [STEPS+1];
    logic                ready_chain [STEPS+1];
    e2q_pkg::e2q_lanes_t lanes_chain [STEPS+1];

    e2q_front #(
        .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .degrees   (degrees_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .angles    (angles),
        .out_valid (valid_chain[0]),
        .out_ready (ready_chain[0]),
        .out_lanes (lanes_chain[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        e2q_cordic_cell #(
            .SHIFT(i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_lanes  (lanes_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_lanes (lanes_chain[i+1])
        );
    end

    e2q_pkg::e2q_quat_t quat;

    e2q_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_chain[STEPS]),
        .in_ready  (ready_chain[STEPS]),
        .in_lanes  (lanes_chain[STEPS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_quat  (quat)
    );

    assign m_axis_tdata = quat;

`ifndef SYNTH
    // an empty or draining output lets the whole row take a new item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(quat.x) <= 16384 && $signed(quat.x) >= -16384 &&
                           $signed(quat.w) <= 16384 && $signed(quat.w) >= -16384))
        else $error("quaternion component out of range");
`endif

endmodule
